// ===== src/prvc_pkg.sv =====
// Shared types and constants for the rail voltage code converter.
// No dependencies; used by prvc_front and the top level.
package prvc_pkg;

  // field widths
  localparam int unsigned VW = 16;           // requested millivolts
  localparam int unsigned CW = 8;            // register code
  localparam int unsigned MW = 15;           // decoded millivolts
  localparam int unsigned XW = 12;           // clamped voltage / segment offset
  localparam int unsigned KW = 16;           // multiplier constant
  localparam int unsigned PW = XW + KW;      // product
  localparam int unsigned RECIP_SHIFT = 19;  // x < 4096: reciprocals below are exact

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // rail numbers
  localparam logic [3:0] RAIL_BUCK1 = 4'd0;
  localparam logic [3:0] RAIL_BUCK2 = 4'd1;
  localparam logic [3:0] RAIL_BUCK3 = 4'd2;
  localparam logic [3:0] RAIL_BUCK4 = 4'd3;
  localparam logic [3:0] RAIL_BUCK5 = 4'd4;
  localparam logic [3:0] RAIL_ALDO1 = 4'd5;
  localparam logic [3:0] RAIL_DLDO1 = 4'd11;
  localparam logic [3:0] RAIL_DLDO2 = 4'd12;
  localparam logic [3:0] RAIL_CPULDO = 4'd13;

  typedef enum logic [2:0] {
    RC_BUCK1,       // 1500..3400, 100 mV
    RC_BUCK23,      // 500..max, 10/20/100 mV segments
    RC_BUCK4,       // 500..1840, 10/20 mV segments
    RC_BUCK5,       // 1400..3700, 100 mV
    RC_LDO_WIDE,    // 500..3400, 100 mV
    RC_LDO_NARROW,  // 500..1400, 100 mV
    RC_NONE         // no voltage setting
  } rail_class_t;

  // range limits, request width
  localparam logic [VW-1:0] V_500  = VW'(500);
  localparam logic [VW-1:0] V_1400 = VW'(1400);
  localparam logic [VW-1:0] V_1500 = VW'(1500);
  localparam logic [VW-1:0] V_1540 = VW'(1540);
  localparam logic [VW-1:0] V_1600 = VW'(1600);
  localparam logic [VW-1:0] V_1840 = VW'(1840);
  localparam logic [VW-1:0] V_3400 = VW'(3400);
  localparam logic [VW-1:0] V_3700 = VW'(3700);

  // segment bounds, clamped width
  localparam logic [XW-1:0] X_500  = XW'(500);
  localparam logic [XW-1:0] X_1220 = XW'(1220);
  localparam logic [XW-1:0] X_1540 = XW'(1540);
  localparam logic [XW-1:0] X_1600 = XW'(1600);

  // segment start codes
  localparam logic [CW-1:0] SEG1_CODE = CW'(8'b0100_0111);  // 71
  localparam logic [CW-1:0] SEG2_CODE = CW'(8'b0101_1000);  // 88
  localparam logic [CW-1:0] BUCK23_CODE_MASK = CW'(8'h7F);

  // floor(x/k) = (x * RECIP_k) >> RECIP_SHIFT for x < 4096
  localparam logic [KW-1:0] RECIP_10  = KW'(((2 ** RECIP_SHIFT) + 9) / 10);
  localparam logic [KW-1:0] RECIP_20  = KW'(((2 ** RECIP_SHIFT) + 19) / 20);
  localparam logic [KW-1:0] RECIP_100 = KW'(((2 ** RECIP_SHIFT) + 99) / 100);

  // decode step sizes and offsets (offsets are two's complement)
  localparam logic [KW-1:0] STEP_10  = KW'(10);
  localparam logic [KW-1:0] STEP_20  = KW'(20);
  localparam logic [KW-1:0] STEP_100 = KW'(100);
  localparam logic [VW-1:0] OFF_P500   = VW'(500);
  localparam logic [VW-1:0] OFF_P1400  = VW'(1400);
  localparam logic [VW-1:0] OFF_P1500  = VW'(1500);
  localparam logic [VW-1:0] OFF_M200   = VW'(-200);
  localparam logic [VW-1:0] OFF_M7200  = VW'(-7200);

  // largest code any rail can produce (buck 3 at 3400 mV)
  localparam logic [CW-1:0] CODE_MAX = CW'(106);

  // stage 1: rail decoded, voltage clamped
  typedef struct packed {
    logic            valid;
    logic            mode;
    logic            ok;
    rail_class_t     rclass;
    logic            low;     // at or below rail minimum
    logic [XW-1:0]   vc;
    logic [XW-1:0]   lo;
    logic [CW-1:0]   d;
  } clamp_t;

  // stage 2: operands for the shared multiplier
  typedef struct packed {
    logic            valid;
    logic            mode;
    logic            ok;
    logic [XW-1:0]   mul_a;
    logic [KW-1:0]   mul_b;
    logic [VW-1:0]   add_off;
  } mul_op_t;

endpackage

// ===== src/prvc_front.sv =====
// Front two pipeline stages: rail decode and clamp, then segment select.
// Depends on prvc_pkg.
module prvc_front import prvc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          mode,
  input  logic [3:0]    rail,
  input  logic [VW-1:0] req_mv,
  input  logic [CW-1:0] code_in,
  output mul_op_t       op_o
);

  clamp_t  s1_nxt, s1_r;
  mul_op_t op_nxt, op_r;
  logic [VW-1:0] lo_v, hi_v;

  // stage 1
  always_comb begin
    s1_nxt        = '0;
    s1_nxt.valid  = in_valid;
    s1_nxt.mode   = mode;
    lo_v          = V_500;
    hi_v          = V_3400;
    case (rail) inside
      RAIL_BUCK1: begin
        s1_nxt.rclass = RC_BUCK1;
        lo_v          = V_1500;
      end
      RAIL_BUCK2: begin
        s1_nxt.rclass = RC_BUCK23;
        hi_v          = V_1540;
      end
      RAIL_BUCK3: s1_nxt.rclass = RC_BUCK23;
      RAIL_BUCK4: begin
        s1_nxt.rclass = RC_BUCK4;
        hi_v          = V_1840;
      end
      RAIL_BUCK5: begin
        s1_nxt.rclass = RC_BUCK5;
        lo_v          = V_1400;
        hi_v          = V_3700;
      end
      [RAIL_ALDO1:RAIL_DLDO1]: s1_nxt.rclass = RC_LDO_WIDE;
      RAIL_DLDO2, RAIL_CPULDO: begin
        s1_nxt.rclass = RC_LDO_NARROW;
        hi_v          = V_1400;
      end
      default: s1_nxt.rclass = RC_NONE;
    endcase
    s1_nxt.ok  = (s1_nxt.rclass != RC_NONE);
    s1_nxt.lo  = lo_v[XW-1:0];
    s1_nxt.low = (req_mv <= lo_v);
    if (req_mv > hi_v) begin
      s1_nxt.vc = hi_v[XW-1:0];
    end else if (s1_nxt.rclass == RC_BUCK23 && req_mv > V_1540 && req_mv < V_1600) begin
      s1_nxt.vc = X_1540;  // gap between segments snaps down
    end else begin
      s1_nxt.vc = req_mv[XW-1:0];
    end
    s1_nxt.d = (s1_nxt.rclass == RC_BUCK23) ? (code_in & BUCK23_CODE_MASK) : code_in;
  end

  // stage 2
  always_comb begin
    op_nxt         = '0;
    op_nxt.valid   = s1_r.valid;
    op_nxt.mode    = s1_r.mode;
    op_nxt.ok      = s1_r.ok;
    op_nxt.mul_b   = RECIP_100;
    if (s1_r.mode == MODE_ENCODE) begin
      if (!s1_r.low) begin
        case (s1_r.rclass)
          RC_BUCK23: begin
            if (s1_r.vc <= X_1220) begin
              op_nxt.mul_a = s1_r.vc - X_500;
              op_nxt.mul_b = RECIP_10;
            end else if (s1_r.vc <= X_1540) begin
              op_nxt.mul_a   = s1_r.vc - X_1220;
              op_nxt.mul_b   = RECIP_20;
              op_nxt.add_off = VW'(SEG1_CODE);
            end else begin
              op_nxt.mul_a   = s1_r.vc - X_1600;
              op_nxt.add_off = VW'(SEG2_CODE);
            end
          end
          RC_BUCK4: begin
            if (s1_r.vc <= X_1220) begin
              op_nxt.mul_a = s1_r.vc - X_500;
              op_nxt.mul_b = RECIP_10;
            end else begin
              op_nxt.mul_a   = s1_r.vc - X_1220;
              op_nxt.mul_b   = RECIP_20;
              op_nxt.add_off = VW'(SEG1_CODE);
            end
          end
          default: op_nxt.mul_a = s1_r.vc - s1_r.lo;
        endcase
      end
    end else begin
      op_nxt.mul_a   = XW'(s1_r.d);
      op_nxt.mul_b   = STEP_100;
      op_nxt.add_off = OFF_P500;
      case (s1_r.rclass)
        RC_BUCK23: begin
          if (s1_r.d < SEG1_CODE) begin
            op_nxt.mul_b = STEP_10;
          end else if (s1_r.d < SEG2_CODE) begin
            op_nxt.mul_b   = STEP_20;
            op_nxt.add_off = OFF_M200;
          end else begin
            op_nxt.add_off = OFF_M7200;
          end
        end
        RC_BUCK4: begin
          if (s1_r.d < SEG1_CODE) begin
            op_nxt.mul_b = STEP_10;
          end else begin
            op_nxt.mul_b   = STEP_20;
            op_nxt.add_off = OFF_M200;
          end
        end
        RC_BUCK1: op_nxt.add_off = OFF_P1500;
        RC_BUCK5: op_nxt.add_off = OFF_P1400;
        default:  op_nxt.add_off = OFF_P500;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      op_r <= '0;
    end else begin
      s1_r <= s1_nxt;
      op_r <= op_nxt;
    end
  end

  assign op_o = op_r;

endmodule

// ===== src/pmic_rail_voltage_code_converter_top.sv =====
// Top level of the rail voltage code converter: four-stage pipeline.
// Depends on prvc_pkg and prvc_front.
//
// Converts between millivolts and the voltage register codes of fourteen
// regulator rails (buck 1-5, aldo 1-4, bldo 1-2, dldo 1-2, cpu ldo).
// Input: drive in_mode, in_rail, in_req_mv, in_code_in and raise start;
//   the item is taken at the rising edge where start is high and busy low.
//   busy never rises, so one item can be taken every cycle.
// Output: out_valid is high for exactly one cycle per item, with
//   out_code_out (encode), out_millivolts (decode) and out_rail_supported.
//   The unused result field reads zero; rails 14 and 15 give all zeros.
// Stages: rail decode and clamp, segment select,
//   one 12x16 multiply (reciprocal for encode, step size for decode),
//   shift and offset add into the output registers.
// Throughput: one item per cycle, set by the single multiplier stage.
// Reset: synchronous, clears the valid bits of every stage; items in flight
//   are dropped. The receiver cannot stall, so nothing is held back.
module pmic_rail_voltage_code_converter_top import prvc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic          in_mode,
  input  logic [3:0]    in_rail,
  input  logic [VW-1:0] in_req_mv,
  input  logic [CW-1:0] in_code_in,
  output logic          out_valid,
  output logic [CW-1:0] out_code_out,
  output logic [MW-1:0] out_millivolts,
  output logic          out_rail_supported
);

  mul_op_t       op;
  logic          s3_valid_r, s3_mode_r, s3_ok_r;
  logic [PW-1:0] s3_prod_r;
  logic [VW-1:0] s3_off_r;

  logic          out_valid_r, out_mode_r, out_ok_r;
  logic [CW-1:0] code_nxt, code_r;
  logic [MW-1:0] mv_nxt, mv_r;
  logic [VW-1:0] mv_sum;

  // pipeline never stalls
  assign busy = 1'b0;

  prvc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start && !busy),
    .mode       (in_mode),
    .rail       (in_rail),
    .req_mv     (in_req_mv),
    .code_in    (in_code_in),
    .op_o       (op)
  );

  // stage 3: multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= op.valid;
    end
    s3_mode_r <= op.mode;
    s3_ok_r   <= op.ok;
    s3_off_r  <= op.add_off;
    s3_prod_r <= PW'(op.mul_a) * PW'(op.mul_b);
  end

  // stage 4: quotient plus segment code, or product plus offset
  assign mv_sum = s3_prod_r[VW-1:0] + s3_off_r;

  always_comb begin
    code_nxt = '0;
    mv_nxt   = '0;
    if (s3_ok_r) begin
      if (s3_mode_r == MODE_ENCODE) begin
        code_nxt = s3_prod_r[RECIP_SHIFT +: CW] + s3_off_r[CW-1:0];
      end else begin
        mv_nxt = mv_sum[MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_valid_r;
    end
    out_mode_r <= s3_mode_r;
    out_ok_r   <= s3_ok_r;
    code_r     <= code_nxt;
    mv_r       <= mv_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_code_out       = code_r;
  assign out_millivolts     = mv_r;
  assign out_rail_supported = out_ok_r;

  // rail without a voltage setting gives an all-zero result
  a_unsupported_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rail_supported |-> out_code_out == '0 && out_millivolts == '0)
    else $error("unsupported rail gave nonzero result");

  // encode results stay in the code range and leave millivolts clear
  a_encode_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_r == MODE_ENCODE |-> out_millivolts == '0 && out_code_out <= CODE_MAX)
    else $error("encode result out of range");

  // decode of a supported rail never goes below 500 mV
  a_decode_floor : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_r == MODE_DECODE && out_rail_supported
      |-> out_code_out == '0 && out_millivolts >= MW'(500))
    else $error("decode result below rail floor");

endmodule
